FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the rasterizer RTL.
// Included by any module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: rtl/core/aalr_pkg.sv
// Shared types and constants for the anti-aliased line rasterizer.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package aalr_pkg;

   localparam int COORD_W  = 6;
   localparam int ALPHA_W  = 8;
   localparam int COLOR_W  = 24;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 72;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AXIS,
      ST_DIV,
      ST_ENDS,
      ST_STEP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic emit_axis;
      logic emit_ends;
      logic emit_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_axis;
      logic div_last;
      logic out_free;
      logic ends_last;
      logic step_last;
      logic axis_last;
   } status_type;

endpackage

FILE: rtl/core/aalr_datapath.sv
// Datapath of the line rasterizer: setup, bit-serial slope divider,
// Wu stepping accumulator and the result output register. Uses aalr_pkg.
`timescale 1ns / 1ps

module aalr_datapath
   import aalr_pkg::*;
#(
   parameter int TILE_WIDTH  = 64,
   parameter int TILE_HEIGHT = 64,
   parameter int FRAC_BITS   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       sts,
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   localparam int ACC_W = FRAC_BITS + COORD_W + 1;
   localparam int Q_W   = FRAC_BITS + 1;
   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam logic [COORD_W:0] TW = (COORD_W + 1)'(TILE_WIDTH);
   localparam logic [COORD_W:0] TH = (COORD_W + 1)'(TILE_HEIGHT);

   function automatic logic in_tile(logic [COORD_W:0] px, logic [COORD_W:0] py);
      return (px < TW) && (py < TH);
   endfunction

   // Input field unpacking.
   logic [COORD_W-1:0] x0, y0, x1, y1;
   logic [COLOR_W-1:0] color;
   assign x0    = req_tdata[5:0];
   assign y0    = req_tdata[11:6];
   assign x1    = req_tdata[17:12];
   assign y1    = req_tdata[23:18];
   assign color = req_tdata[47:24];

   // Segment state.
   logic               axis_ff, steep_ff, down_ff, horiz_ff;
   logic [COORD_W:0]   pos_ff, stop_ff;
   logic [COORD_W-1:0] fix_ff, dmaj_ff;
   logic [COORD_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [COORD_W:0]   rem_ff;
   logic [Q_W-1:0]     quo_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [COLOR_W-1:0] color_ff;
   logic               rsp_valid_ff, rsp_last_ff;
   logic [RSP_W-1:0]   rsp_data_ff;

   // Setup logic: octant choice, endpoint ordering and deltas.
   logic               horiz, vert, steep;
   logic [COORD_W-1:0] dx, dy, m0r, m1r, n0r, n1r, m0, m1, n0, n1, dmaj, dmin;
   logic [COORD_W-1:0] am0, am1, alo, ahi;
   always_comb begin
      horiz = (y0 == y1);
      vert  = (x0 == x1);
      dx    = (x0 > x1) ? x0 - x1 : x1 - x0;
      dy    = (y0 > y1) ? y0 - y1 : y1 - y0;
      steep = (dy > dx);
      m0r   = steep ? y0 : x0;
      m1r   = steep ? y1 : x1;
      n0r   = steep ? x0 : y0;
      n1r   = steep ? x1 : y1;
      if (m0r > m1r) begin
         m0 = m1r; m1 = m0r; n0 = n1r; n1 = n0r;
      end else begin
         m0 = m0r; m1 = m1r; n0 = n0r; n1 = n1r;
      end
      dmaj = m1 - m0;
      dmin = (n1 < n0) ? n0 - n1 : n1 - n0;
      am0  = horiz ? x0 : y0;
      am1  = horiz ? x1 : y1;
      alo  = (am0 > am1) ? am1 : am0;
      ahi  = (am0 > am1) ? am0 : am1;
   end

   // Divider step: one quotient bit per cycle, remainder stays below 2 * dmaj.
   logic               div_ge;
   logic [COORD_W:0]   div_diff;
   always_comb begin
      div_ge   = (rem_ff >= {1'b0, dmaj_ff});
      div_diff = rem_ff - (div_ge ? {1'b0, dmaj_ff} : '0);
   end

   // Interior step: advance the minor accumulator and form the pixel pair.
   logic [ACC_W-1:0]   acc_nx, slope_ext;
   logic [COORD_W:0]   fl, fl1;
   logic [ALPHA_W-1:0] cb;
   always_comb begin
      slope_ext = ACC_W'(quo_ff);
      acc_nx    = down_ff ? acc_ff - slope_ext : acc_ff + slope_ext;
      fl        = acc_nx[ACC_W-1:FRAC_BITS];
      fl1       = fl + 1'b1;
      cb        = acc_nx[FRAC_BITS-1:FRAC_BITS-ALPHA_W];
   end

   // Result word of the current emit command.
   logic [RSP_W-1:0] emit_data;
   logic             emit_last;
   logic [COORD_W:0] px_a, py_a, px_b, py_b;
   always_comb begin
      px_a = '0; py_a = '0; px_b = '0; py_b = '0;
      emit_data = '0;
      emit_last = 1'b0;
      priority if (cmd.emit_axis) begin
         px_a = horiz_ff ? pos_ff : {1'b0, fix_ff};
         py_a = horiz_ff ? {1'b0, fix_ff} : pos_ff;
         emit_data = {6'b0, color_ff, 1'b0, 8'h00, 6'b0, 6'b0,
                      in_tile(px_a, py_a), 8'hFF, py_a[5:0], px_a[5:0]};
         emit_last = (pos_ff == stop_ff);
      end else if (cmd.emit_ends) begin
         px_a = {1'b0, ax_ff}; py_a = {1'b0, ay_ff};
         px_b = {1'b0, bx_ff}; py_b = {1'b0, by_ff};
         emit_data = {6'b0, color_ff, in_tile(px_b, py_b), 8'hFF, by_ff, bx_ff,
                      in_tile(px_a, py_a), 8'hFF, ay_ff, ax_ff};
         emit_last = sts.ends_last;
      end else if (cmd.emit_step) begin
         px_a = steep_ff ? fl : pos_ff;
         py_a = steep_ff ? pos_ff : fl;
         px_b = steep_ff ? fl1 : pos_ff;
         py_b = steep_ff ? pos_ff : fl1;
         emit_data = {6'b0, color_ff, in_tile(px_b, py_b), cb, py_b[5:0], px_b[5:0],
                      in_tile(px_a, py_a), 8'hFF - cb, py_a[5:0], px_a[5:0]};
         emit_last = sts.step_last;
      end
   end

   // Segment registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         axis_ff  <= horiz | vert;
         horiz_ff <= horiz;
         steep_ff <= (horiz | vert) ? ~horiz : steep;
         pos_ff   <= (horiz | vert) ? {1'b0, alo} : {1'b0, m0};
         stop_ff  <= (horiz | vert) ? {1'b0, ahi} : {1'b0, m1};
         fix_ff   <= horiz ? y0 : x0;
         dmaj_ff  <= dmaj;
         down_ff  <= (n1 < n0);
         acc_ff   <= ACC_W'({n0, {FRAC_BITS{1'b0}}});
         rem_ff   <= {1'b0, dmin};
         quo_ff   <= '0;
         cnt_ff   <= CNT_W'(FRAC_BITS);
         ax_ff    <= steep ? n0 : m0;
         ay_ff    <= steep ? m0 : n0;
         bx_ff    <= steep ? n1 : m1;
         by_ff    <= steep ? m1 : n1;
         color_ff <= color;
      end
      if (cmd.div_step) begin
         rem_ff <= {div_diff[COORD_W-1:0], 1'b0};
         quo_ff <= {quo_ff[Q_W-2:0], div_ge};
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.emit_axis || cmd.emit_ends) begin
         pos_ff <= pos_ff + 1'b1;
      end
      if (cmd.emit_step) begin
         pos_ff <= pos_ff + 1'b1;
         acc_ff <= acc_nx;
      end
   end

   // Output register: a finished result waits here for its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_axis || cmd.emit_ends || cmd.emit_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_axis || cmd.emit_ends || cmd.emit_step) begin
         rsp_data_ff <= emit_data;
         rsp_last_ff <= emit_last;
      end
   end

   // Status toward the controller.
   always_comb begin
      sts.is_axis   = axis_ff;
      sts.div_last  = (cnt_ff == '0);
      sts.out_free  = ~rsp_valid_ff | rsp_tready;
      sts.ends_last = (dmaj_ff <= COORD_W'(1));
      sts.step_last = ((pos_ff + 1'b1) == stop_ff);
      sts.axis_last = (pos_ff == stop_ff);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/core/aalr_ctrl.sv
// Controller state machine of the line rasterizer.
// Uses aalr_pkg and assert_macros.svh; drives commands into aalr_datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aalr_ctrl
   import aalr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.is_axis) begin
               state_in = ST_AXIS;
            end else if (sts.div_last) begin
               state_in = ST_ENDS;
            end
         end
         ST_AXIS: begin
            if (sts.out_free && sts.axis_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_ENDS: begin
            if (sts.out_free) begin
               state_in = sts.ends_last ? ST_IDLE : ST_STEP;
            end
         end
         ST_STEP: begin
            if (sts.out_free && sts.step_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DIV:  cmd.div_step  = ~sts.is_axis;
         ST_AXIS: cmd.emit_axis = sts.out_free;
         ST_ENDS: cmd.emit_ends = sts.out_free;
         ST_STEP: cmd.emit_step = sts.out_free;
         default: cmd = '0;
      endcase
   end

   // A result is only ever written into a free output register.
   `ASSERT_HOLDS(a_emit_free, clock, reset, (cmd.emit_axis || cmd.emit_ends || cmd.emit_step) |-> sts.out_free, "emit into occupied output register")
   // At most one datapath command per cycle.
   `ASSERT_HOLDS(a_cmd_onehot, clock, reset, $onehot0({cmd.load, cmd.div_step, cmd.emit_axis, cmd.emit_ends, cmd.emit_step}), "conflicting datapath commands")
   // A sloped segment leaves the divider only once every quotient bit is in.
   `ASSERT_HOLDS(a_div_done, clock, reset, (state_ff == ST_DIV && state_in == ST_ENDS) |-> sts.div_last, "divider left early")
   // Interior steps never run past the far endpoint.
   `ASSERT_NEVER(a_step_range, clock, reset, cmd.emit_step && sts.axis_last, "interior step reached the end")

endmodule

FILE: rtl/core/antialiased_line_rasterizer.sv
// Top level of the anti-aliased (Wu) line rasterizer for one tile.
// Instantiates aalr_ctrl and aalr_datapath; uses aalr_pkg.
//
//   Channel   Direction  Transfer carries
//   req_*     in         one segment: endpoints and color (48-bit tdata)
//   rsp_*     out        one result: up to two pixel writes, color; tlast ends a line
//
// A segment is taken only while no segment is in progress.
// Axis-aligned segments skip the division steps, then give one pixel in each result.
// Sloped segments first run the bit-serial slope divider, then give one result per cycle
// while rsp_tready does not stall (endpoints, then interior steps).
// Results wait in an output register; a stalled rsp_tready holds the stepping.
// Reset is synchronous and clears only the controller and the output valid.
`timescale 1ns / 1ps

module antialiased_line_rasterizer
   import aalr_pkg::*;
#(
   parameter int TILE_WIDTH  = 64,
   parameter int TILE_HEIGHT = 64,
   parameter int FRAC_BITS   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], line_color[47:24]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // pix_a_x[5:0], pix_a_y[11:6], pix_a_alpha[19:12], pix_a_valid[20],
   // pix_b_x[26:21], pix_b_y[32:27], pix_b_alpha[40:33], pix_b_valid[41],
   // pixel_color[65:42], zero fill[71:66]
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   cmd_type    cmd;
   status_type sts;

   aalr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   aalr_datapath #(
      .TILE_WIDTH  (TILE_WIDTH),
      .TILE_HEIGHT (TILE_HEIGHT),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
